[src/sssp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_pkg: shared definitions for the shortest-path engine
// Field widths, reset constants, the stored edge layout and the sequencer
// states used by the single-source shortest path block.
// ----------------------------------------------------------------------------
package sssp_pkg;

    localparam int VERT_W   = 6;
    localparam int WEIGHT_W = 16;
    localparam int DIST_W   = 32;
    localparam int VCOUNT_W = 7;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 256;

    localparam logic [VCOUNT_W-1:0]      VCOUNT_RESET   = 7'd64;
    localparam logic signed [DIST_W-1:0] UNREACHED_DIST = 32'sd100000000;

    typedef struct packed {
        logic [VERT_W-1:0]          from_vertex;
        logic [VERT_W-1:0]          to_vertex;
        logic signed [WEIGHT_W-1:0] weight;
    } edge_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_EDGE_RD,
        ST_DIST_RD,
        ST_ADD,
        ST_CMP,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

endpackage

[src/sssp_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_ifs: valid/ready channels of the shortest-path engine
// One channel carries incoming edges, the other carries distance results.
// ----------------------------------------------------------------------------
interface sssp_edge_if;
    import sssp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [VERT_W-1:0]          from_vertex;
    logic [VERT_W-1:0]          to_vertex;
    logic signed [WEIGHT_W-1:0] weight;
    logic                       last_edge;

    modport source (output valid, from_vertex, to_vertex, weight, last_edge,
                    input ready);
    modport sink   (input valid, from_vertex, to_vertex, weight, last_edge,
                    output ready);
endinterface

interface sssp_result_if;
    import sssp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [VERT_W-1:0]        vertex_index;
    logic signed [DIST_W-1:0] distance;
    logic                     reachable;
    logic                     negative_cycle;
    logic                     edge_overflow;
    logic                     last_result;

    modport source (output valid, vertex_index, distance, reachable,
                    negative_cycle, edge_overflow, last_result,
                    input ready);
    modport sink   (input valid, vertex_index, distance, reachable,
                    negative_cycle, edge_overflow, last_result,
                    output ready);
endinterface

[src/sssp_edge_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_edge_mem: edge store
// Single-port-write, single-port-read memory holding one edge per entry,
// with registered read data that holds until the next read.
// ----------------------------------------------------------------------------
module sssp_edge_mem #(
    parameter int DEPTH = sssp_pkg::DEF_MAX_EDGES,
    parameter int AW    = 8
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  sssp_pkg::edge_t wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output sssp_pkg::edge_t rdata
);
    import sssp_pkg::*;

    edge_t mem [DEPTH];
    edge_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/sssp_dist_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_dist_mem: distance store
// One write port and two read ports with registered read data. Read data
// holds until the next read enable.
// ----------------------------------------------------------------------------
module sssp_dist_mem #(
    parameter int DEPTH = sssp_pkg::DEF_MAX_VERTICES,
    parameter int AW    = 6
) (
    input  logic                               clk,
    input  logic                               we,
    input  logic [AW-1:0]                      waddr,
    input  logic signed [sssp_pkg::DIST_W-1:0] wdata,
    input  logic                               re,
    input  logic [AW-1:0]                      raddr_a,
    input  logic [AW-1:0]                      raddr_b,
    output logic signed [sssp_pkg::DIST_W-1:0] rdata_a,
    output logic signed [sssp_pkg::DIST_W-1:0] rdata_b
);
    import sssp_pkg::*;

    logic signed [DIST_W-1:0] mem [DEPTH];
    logic signed [DIST_W-1:0] rdata_a_reg;
    logic signed [DIST_W-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

[src/sssp_relax_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssp_relax_unit: shared edge relaxation datapath
// Forms the saturating candidate distance into a register, then compares it
// against the current distance of the destination vertex.
// ----------------------------------------------------------------------------
module sssp_relax_unit (
    input  logic                                 clk,
    input  logic                                 load,
    input  logic signed [sssp_pkg::DIST_W-1:0]   dist_from,
    input  logic signed [sssp_pkg::WEIGHT_W-1:0] weight,
    input  logic signed [sssp_pkg::DIST_W-1:0]   dist_to,
    input  logic                                 reached_to,
    output logic signed [sssp_pkg::DIST_W-1:0]   cand,
    output logic                                 improve
);
    import sssp_pkg::*;

    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    logic signed [DIST_W:0]   sum;
    logic signed [DIST_W-1:0] sat;
    logic signed [DIST_W-1:0] cand_reg;

    assign sum = {dist_from[DIST_W-1], dist_from}
               + {{(DIST_W+1-WEIGHT_W){weight[WEIGHT_W-1]}}, weight};

    // The top two bits disagree exactly when the sum left the 32-bit range.
    always_comb
    begin
        if (sum[DIST_W] != sum[DIST_W-1])
        begin
            sat = sum[DIST_W] ? DIST_MIN : DIST_MAX;
        end
        else
        begin
            sat = sum[DIST_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cand_reg <= sat;
        end
    end

    assign cand    = cand_reg;
    assign improve = !reached_to || (cand_reg < dist_to);

endmodule

[src/single_source_shortest_path.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_source_shortest_path: Bellman-Ford engine from vertex 0
// Stores weighted edges, relaxes them pass by pass through one shared
// add/compare unit, checks for a negative cycle and streams the distances.
// ----------------------------------------------------------------------------
//  Channel     Dir  Handshake        Payload
//  edge_in     in   valid / ready    from_vertex, to_vertex, weight, last_edge
//  result_out  out  valid / ready    vertex_index, distance, reachable,
//                                    negative_cycle, edge_overflow, last_result
//  cfg         in   cfg_wr_en        cfg_wr_data (vertex_count)
//
//  Edges load at one per cycle. After the last edge, the sequencer passes an
//  init state, then steps each edge through edge read, distance read and add
//  (and compare if relaxed) over up to n-1 passes and one check pass; the
//  single edge memory read port and the shared relax unit set this order.
//  Each result is read, then loaded once the output is free. The input is not
//  ready from the last edge until the last result sits in the output register.
//  Reset clears the control state and sets vertex_count to 64; the memories
//  need no clearing, since per-vertex reached bits qualify the distances.
// ----------------------------------------------------------------------------
module single_source_shortest_path #(
    parameter int MAX_VERTICES = sssp_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = sssp_pkg::DEF_MAX_EDGES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [sssp_pkg::VCOUNT_W-1:0]     cfg_wr_data,
    sssp_edge_if.sink                         edge_in,
    sssp_result_if.source                     result_out
);
    import sssp_pkg::*;

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int NW  = $clog2(MAX_VERTICES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW  = $clog2(MAX_EDGES + 1);

    state_t                   state_reg, state_next;
    logic [VCOUNT_W-1:0]      vcount_reg, vcount_next;
    logic [NW-1:0]            n_reg, n_next;
    logic [CW-1:0]            fill_reg, fill_next;
    logic [CW-1:0]            k_reg, k_next;
    logic [VW-1:0]            pass_reg, pass_next;
    logic [VW-1:0]            i_reg, i_next;
    logic                     overflow_reg, overflow_next;
    logic                     any_reg, any_next;
    logic                     checking_reg, checking_next;
    logic                     cycle_reg, cycle_next;
    logic [MAX_VERTICES-1:0]  reached_reg, reached_next;
    logic                     out_valid_reg, out_valid_next;

    logic [VERT_W-1:0]        out_index_reg;
    logic signed [DIST_W-1:0] out_dist_reg;
    logic                     out_reach_reg;
    logic                     out_neg_reg;
    logic                     out_ovf_reg;
    logic                     out_last_reg;

    logic                     in_xfer;
    logic                     out_load;
    logic                     out_is_last;
    logic [NW-1:0]            n_clamp;

    edge_t                    edge_wdata;
    edge_t                    edge_rdata;
    logic                     edge_re;

    logic                     dist_we;
    logic [VW-1:0]            dist_waddr;
    logic signed [DIST_W-1:0] dist_wdata;
    logic                     dist_re;
    logic [VW-1:0]            dist_raddr_a;
    logic signed [DIST_W-1:0] dist_rdata_a;
    logic signed [DIST_W-1:0] dist_rdata_b;

    logic [VW-1:0]            from_idx;
    logic [VW-1:0]            to_idx;
    logic                     edge_skip;
    logic                     relax_load;
    logic signed [DIST_W-1:0] cand;
    logic                     improve;

    assign edge_in.ready = (state_reg == ST_LOAD);
    assign in_xfer       = edge_in.valid && edge_in.ready;

    assign edge_wdata.from_vertex = edge_in.from_vertex;
    assign edge_wdata.to_vertex   = edge_in.to_vertex;
    assign edge_wdata.weight      = edge_in.weight;

    assign from_idx = edge_rdata.from_vertex[VW-1:0];
    assign to_idx   = edge_rdata.to_vertex[VW-1:0];

    // Edges whose endpoints lie outside the graph, or whose source has not
    // been reached yet, take no part in the pass.
    assign edge_skip = (VCOUNT_W'(edge_rdata.from_vertex) >= VCOUNT_W'(n_reg))
                    || (VCOUNT_W'(edge_rdata.to_vertex) >= VCOUNT_W'(n_reg))
                    || !reached_reg[from_idx];

    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_clamp = NW'(1);
        end
        else if (vcount_reg > VCOUNT_W'(MAX_VERTICES))
        begin
            n_clamp = NW'(MAX_VERTICES);
        end
        else
        begin
            n_clamp = NW'(vcount_reg);
        end
    end

    assign out_load    = (state_reg == ST_OUT_LD)
                      && (!out_valid_reg || result_out.ready);
    assign out_is_last = cycle_reg || ((NW'(i_reg) + NW'(1)) == n_reg);

    assign edge_re      = (state_reg == ST_EDGE_RD) && (k_reg != fill_reg);
    assign dist_re      = (state_reg == ST_DIST_RD) || (state_reg == ST_OUT_RD);
    assign dist_raddr_a = (state_reg == ST_OUT_RD) ? i_reg : from_idx;
    assign relax_load   = (state_reg == ST_ADD) && !edge_skip;

    always_comb
    begin
        if (state_reg == ST_INIT)
        begin
            dist_we    = 1'b1;
            dist_waddr = '0;
            dist_wdata = '0;
        end
        else
        begin
            dist_we    = (state_reg == ST_CMP) && improve && !checking_reg;
            dist_waddr = to_idx;
            dist_wdata = cand;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        vcount_next    = cfg_wr_en ? cfg_wr_data : vcount_reg;
        n_next         = n_reg;
        fill_next      = fill_reg;
        k_next         = k_reg;
        pass_next      = pass_reg;
        i_next         = i_reg;
        overflow_next  = overflow_reg;
        any_next       = any_reg;
        checking_next  = checking_reg;
        cycle_next     = cycle_reg;
        reached_next   = reached_reg;
        out_valid_next = out_valid_reg;

        if (result_out.valid && result_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (fill_reg < CW'(MAX_EDGES))
                    begin
                        fill_next = fill_reg + CW'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (edge_in.last_edge)
                    begin
                        n_next     = n_clamp;
                        state_next = ST_INIT;
                    end
                end
            end

            ST_INIT:
            begin
                reached_next    = '0;
                reached_next[0] = 1'b1;
                pass_next       = '0;
                k_next          = '0;
                any_next        = 1'b0;
                // A one-vertex graph goes straight to the cycle check.
                checking_next   = (n_reg < NW'(2));
                state_next      = ST_EDGE_RD;
            end

            ST_EDGE_RD:
            begin
                if (k_reg == fill_reg)
                begin
                    k_next   = '0;
                    any_next = 1'b0;
                    if (checking_reg)
                    begin
                        cycle_next = any_reg;
                        i_next     = '0;
                        state_next = ST_OUT_RD;
                    end
                    else if (any_reg
                             && ((NW+1)'(pass_reg) + (NW+1)'(2) < (NW+1)'(n_reg)))
                    begin
                        pass_next = pass_reg + VW'(1);
                    end
                    else
                    begin
                        checking_next = 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_DIST_RD;
                end
            end

            ST_DIST_RD:
            begin
                state_next = ST_ADD;
            end

            ST_ADD:
            begin
                if (edge_skip)
                begin
                    k_next     = k_reg + CW'(1);
                    state_next = ST_EDGE_RD;
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end

            ST_CMP:
            begin
                if (improve)
                begin
                    any_next = 1'b1;
                    if (!checking_reg)
                    begin
                        reached_next[to_idx] = 1'b1;
                    end
                end
                k_next     = k_reg + CW'(1);
                state_next = ST_EDGE_RD;
            end

            ST_OUT_RD:
            begin
                state_next = ST_OUT_LD;
            end

            ST_OUT_LD:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    if (out_is_last)
                    begin
                        fill_next     = '0;
                        overflow_next = 1'b0;
                        pass_next     = '0;
                        any_next      = 1'b0;
                        checking_next = 1'b0;
                        state_next    = ST_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + VW'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            vcount_reg    <= VCOUNT_RESET;
            n_reg         <= '0;
            fill_reg      <= '0;
            k_reg         <= '0;
            pass_reg      <= '0;
            i_reg         <= '0;
            overflow_reg  <= 1'b0;
            any_reg       <= 1'b0;
            checking_reg  <= 1'b0;
            cycle_reg     <= 1'b0;
            reached_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vcount_reg    <= vcount_next;
            n_reg         <= n_next;
            fill_reg      <= fill_next;
            k_reg         <= k_next;
            pass_reg      <= pass_next;
            i_reg         <= i_next;
            overflow_reg  <= overflow_next;
            any_reg       <= any_next;
            checking_reg  <= checking_next;
            cycle_reg     <= cycle_next;
            reached_reg   <= reached_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ovf_reg  <= overflow_reg;
            out_last_reg <= out_is_last;
            if (cycle_reg)
            begin
                out_index_reg <= '0;
                out_dist_reg  <= '0;
                out_reach_reg <= 1'b0;
                out_neg_reg   <= 1'b1;
            end
            else
            begin
                out_index_reg <= VERT_W'(i_reg);
                out_dist_reg  <= reached_reg[i_reg] ? dist_rdata_a : UNREACHED_DIST;
                out_reach_reg <= reached_reg[i_reg];
                out_neg_reg   <= 1'b0;
            end
        end
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.vertex_index   = out_index_reg;
    assign result_out.distance       = out_dist_reg;
    assign result_out.reachable      = out_reach_reg;
    assign result_out.negative_cycle = out_neg_reg;
    assign result_out.edge_overflow  = out_ovf_reg;
    assign result_out.last_result    = out_last_reg;

    sssp_edge_mem #(
        .DEPTH (MAX_EDGES),
        .AW    (EAW)
    ) u_edge_mem (
        .clk   (clk),
        .we    (in_xfer && (fill_reg < CW'(MAX_EDGES))),
        .waddr (fill_reg[EAW-1:0]),
        .wdata (edge_wdata),
        .re    (edge_re),
        .raddr (k_reg[EAW-1:0]),
        .rdata (edge_rdata)
    );

    sssp_dist_mem #(
        .DEPTH (MAX_VERTICES),
        .AW    (VW)
    ) u_dist_mem (
        .clk     (clk),
        .we      (dist_we),
        .waddr   (dist_waddr),
        .wdata   (dist_wdata),
        .re      (dist_re),
        .raddr_a (dist_raddr_a),
        .raddr_b (to_idx),
        .rdata_a (dist_rdata_a),
        .rdata_b (dist_rdata_b)
    );

    sssp_relax_unit u_relax_unit (
        .clk        (clk),
        .load       (relax_load),
        .dist_from  (dist_rdata_a),
        .weight     (edge_rdata.weight),
        .dist_to    (dist_rdata_b),
        .reached_to (reached_reg[to_idx]),
        .cand       (cand),
        .improve    (improve)
    );

`ifndef NO_ASSERTIONS
    // The edge store never counts past its capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(MAX_EDGES))
    else $error("edge fill count exceeds store capacity");

    // The check pass must leave the distances untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (dist_we && (state_reg == ST_CMP)) |-> !checking_reg)
    else $error("distance written during negative cycle check");

    // A result still waiting in the output register is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || result_out.ready))
    else $error("pending result overwritten");

    // Loading the final result of a graph reopens the edge input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_is_last) |=> (edge_in.ready && (fill_reg == '0)))
    else $error("edge input not reopened after final result");
`endif

endmodule
